### sv/sft_pkg.sv
// Package for the sorted fitness table: command codes, status codes,
// field widths and the control bundle broadcast to the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sft_pkg;

  // Fixed widths of the item fields
  localparam int CMD_W   = 3;
  localparam int RANK_W  = 5;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 6;
  localparam int STAT_W  = 2;
  localparam int FCOST_W = 64;

  // Parameter defaults
  localparam int DEF_POP_DEPTH = 32;
  localparam int DEF_COST_BITS = 64;

  // Reset value of the population limit register
  localparam logic [CNT_W-1:0] MAX_POP_RESET = CNT_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_REPLACE = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_READ    = 3'd4
  } sft_cmd_t;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANK = 2'd2;

  // Control broadcast to every cell in the row
  typedef struct packed {
    logic             apply;   // shift the row and place the new cost
    logic             lookup;  // select the lookup hit instead of addr
    logic             clear;   // return slots to their reset owners
    logic [CNT_W-1:0] addr;    // target rank (count for insert)
    logic [CNT_W-1:0] count;   // entries currently held
  } sft_ctl_t;

endpackage

`default_nettype wire

### sv/sft_cell.sv
// One rank of the sorted fitness table: a cost and a buffer slot, with the
// compare against the broadcast cost and the shift decision for its rank.
// Depends on sft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sft_cell #(
  parameter int COST_BITS = sft_pkg::DEF_COST_BITS,
  parameter int INDEX     = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sft_pkg::sft_ctl_t            ctl,
  input  wire logic signed [COST_BITS-1:0]  new_cost,
  input  wire logic [sft_pkg::SLOT_W-1:0]   mv_slot,
  // left neighbor (rank INDEX-1)
  input  wire logic                         left_gt,
  input  wire logic                         left_lt,
  input  wire logic signed [COST_BITS-1:0]  left_cost,
  input  wire logic [sft_pkg::SLOT_W-1:0]   left_slot,
  // right neighbor (rank INDEX+1)
  input  wire logic                         right_lt,
  input  wire logic signed [COST_BITS-1:0]  right_cost,
  input  wire logic [sft_pkg::SLOT_W-1:0]   right_slot,
  // to neighbors
  output logic                              gt,
  output logic                              lt,
  output logic signed [COST_BITS-1:0]       cost,
  output logic [sft_pkg::SLOT_W-1:0]        slot,
  // to the result logic
  output logic                              put,
  output logic                              hit,
  output logic [sft_pkg::RANK_W-1:0]        rank_code,
  output logic signed [COST_BITS-1:0]       sel_cost,
  output logic [sft_pkg::SLOT_W-1:0]        sel_slot
);
  import sft_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_INIT = SLOT_W'(INDEX);

  logic occupied;
  logic eq;
  logic below;
  logic at;
  logic take_left;
  logic take_right;
  logic place;
  logic sel;

  // Compare the held cost with the broadcast cost
  always_comb begin
    occupied = int'(ctl.count) > INDEX;
    gt       = occupied && (new_cost < cost);
    lt       = occupied && (cost < new_cost);
    eq       = occupied && (cost == new_cost);
  end

  // Decide what this rank takes: left neighbor, right neighbor or new cost
  always_comb begin
    below      = int'(ctl.addr) > INDEX;
    at         = int'(ctl.addr) == INDEX;
    take_left  = (below || at) && left_gt;
    take_right = (!below && !at && right_lt) || (at && !left_gt && right_lt);
    if (below) begin
      place = gt && !left_gt;
    end else if (at) begin
      place = !left_gt && !right_lt;
    end else begin
      place = lt && !right_lt;
    end
    put = ctl.apply && place;
    // lowest rank whose cost is not below the key, and equal to it
    hit = ctl.lookup && eq && left_lt;
  end

  // Drive the select bus and the rank code
  always_comb begin
    sel       = ctl.lookup ? hit : at;
    sel_cost  = sel ? cost : '0;
    sel_slot  = sel ? slot : '0;
    rank_code = (put || hit) ? RANK_W'(INDEX) : '0;
  end

  // Cost register: no reset, only occupied ranks are ever read
  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (take_left) begin
        cost <= left_cost;
      end else if (take_right) begin
        cost <= right_cost;
      end else if (place) begin
        cost <= new_cost;
      end
    end
  end

  // Slot register: reset and clear return it to its own buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_INIT;
    end else if (ctl.clear) begin
      slot <= SLOT_INIT;
    end else if (ctl.apply) begin
      if (take_left) begin
        slot <= left_slot;
      end else if (take_right) begin
        slot <= right_slot;
      end else if (place) begin
        slot <= mv_slot;
      end
    end
  end

endmodule

`default_nettype wire

### sv/sorted_fitness_table_unit.sv
// Sorted fitness table: a row of cells kept in rising cost order, with the
// command register, result register and population limit register.
// Depends on sft_pkg and sft_cell.
//
// The table holds up to min(max_population, POP_DEPTH) entries in a row of
// POP_DEPTH cells, one per rank, each with its own cost comparator. A command
// beat is taken into the command register and executed once the result
// register is free: every cell compares against the command's cost at once
// and the whole row shifts as the command executes. Every command, insert,
// lookup, replace, clear or read, is registered the same way, and a new beat
// is taken in the cycle the previous one executes, giving one command per
// cycle while results are taken. A held result stalls execution of the next
// command. Reset and clear take effect at once; there is no clearing pass.
// Costs use the low COST_BITS bits of the cost field as a signed value, and
// entry_cost is sign extended from COST_BITS. The configuration port is always
// ready and should be written only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

module sorted_fitness_table_unit #(
  parameter int POP_DEPTH = sft_pkg::DEF_POP_DEPTH,
  parameter int COST_BITS = sft_pkg::DEF_COST_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // command channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sft_pkg::CMD_W-1:0]    cmd,
  input  wire logic signed [sft_pkg::FCOST_W-1:0] cost,
  input  wire logic [sft_pkg::RANK_W-1:0]   rank,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sft_pkg::STAT_W-1:0]        status,
  output logic                              found,
  output logic [sft_pkg::RANK_W-1:0]        final_rank,
  output logic [sft_pkg::SLOT_W-1:0]        buffer_slot,
  output logic signed [sft_pkg::FCOST_W-1:0] entry_cost,
  output logic [sft_pkg::CNT_W-1:0]         population_count,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sft_pkg::CNT_W-1:0]    cfg_data
);
  import sft_pkg::*;

  // Command register and control
  logic                        busy;
  logic [CMD_W-1:0]            cmd_q;
  logic signed [COST_BITS-1:0] cost_q;
  logic [RANK_W-1:0]           rank_q;
  logic [CNT_W-1:0]            max_pop;
  logic [CNT_W-1:0]            count;
  logic                        exec_fire;
  logic                        in_accept;

  // Row wiring
  sft_ctl_t                    ctl;
  logic [SLOT_W-1:0]           mv_slot;
  logic                        gt_v   [POP_DEPTH];
  logic                        lt_v   [POP_DEPTH];
  logic signed [COST_BITS-1:0] cost_v [POP_DEPTH];
  logic [SLOT_W-1:0]           slot_v [POP_DEPTH];
  logic [POP_DEPTH-1:0]        put_vec;
  logic [POP_DEPTH-1:0]        hit_vec;
  logic [RANK_W-1:0]           code_v [POP_DEPTH];
  logic signed [COST_BITS-1:0] scost_v[POP_DEPTH];
  logic [SLOT_W-1:0]           sslot_v[POP_DEPTH];

  // Reduced row outputs
  logic                        any_hit;
  logic [RANK_W-1:0]           row_rank;
  logic signed [COST_BITS-1:0] row_cost;
  logic [SLOT_W-1:0]           row_slot;

  // Decoded command
  logic                        is_insert;
  logic                        is_replace;
  logic                        full;
  logic                        rank_ok;

  // Result next values
  logic [STAT_W-1:0]           status_next;
  logic                        found_next;
  logic [RANK_W-1:0]           final_rank_next;
  logic [SLOT_W-1:0]           buffer_slot_next;
  logic signed [FCOST_W-1:0]   entry_cost_next;
  logic [CNT_W-1:0]            count_next;

  // Handshake: execute when the result register is free
  assign exec_fire = busy && (!out_valid || !out_stall);
  assign in_stall  = busy && !exec_fire;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Hold the command beat until it executes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_accept) begin
      busy <= 1'b1;
    end else if (exec_fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= cmd;
      cost_q <= cost[COST_BITS-1:0];
      rank_q <= rank;
    end
  end

  // Population limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_pop <= MAX_POP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_pop <= cfg_data;
    end
  end

  // Decode the held command and build the row control
  always_comb begin
    is_insert   = cmd_q == CMD_INSERT;
    is_replace  = cmd_q == CMD_REPLACE;
    full        = (count >= max_pop) || (int'(count) >= POP_DEPTH);
    rank_ok     = CNT_W'(rank_q) < count;
    ctl.apply   = exec_fire && ((is_insert && !full) || (is_replace && rank_ok));
    ctl.lookup  = cmd_q == CMD_LOOKUP;
    ctl.clear   = exec_fire && (cmd_q == CMD_CLEAR);
    ctl.addr    = is_insert ? count : CNT_W'(rank_q);
    ctl.count   = count;
  end

  // Row of cells, each linked to its neighbors
  for (genvar j = 0; j < POP_DEPTH; j++) begin : g_cell
    logic                        l_gt;
    logic                        l_lt;
    logic signed [COST_BITS-1:0] l_cost;
    logic [SLOT_W-1:0]           l_slot;
    logic                        r_lt;
    logic signed [COST_BITS-1:0] r_cost;
    logic [SLOT_W-1:0]           r_slot;

    if (j == 0) begin : g_left_end
      assign l_gt   = 1'b0;
      assign l_lt   = 1'b1;
      assign l_cost = '0;
      assign l_slot = '0;
    end else begin : g_left
      assign l_gt   = gt_v[j-1];
      assign l_lt   = lt_v[j-1];
      assign l_cost = cost_v[j-1];
      assign l_slot = slot_v[j-1];
    end

    if (j == POP_DEPTH - 1) begin : g_right_end
      assign r_lt   = 1'b0;
      assign r_cost = '0;
      assign r_slot = '0;
    end else begin : g_right
      assign r_lt   = lt_v[j+1];
      assign r_cost = cost_v[j+1];
      assign r_slot = slot_v[j+1];
    end

    sft_cell #(
      .COST_BITS (COST_BITS),
      .INDEX     (j)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_cost   (cost_q),
      .mv_slot    (mv_slot),
      .left_gt    (l_gt),
      .left_lt    (l_lt),
      .left_cost  (l_cost),
      .left_slot  (l_slot),
      .right_lt   (r_lt),
      .right_cost (r_cost),
      .right_slot (r_slot),
      .gt         (gt_v[j]),
      .lt         (lt_v[j]),
      .cost       (cost_v[j]),
      .slot       (slot_v[j]),
      .put        (put_vec[j]),
      .hit        (hit_vec[j]),
      .rank_code  (code_v[j]),
      .sel_cost   (scost_v[j]),
      .sel_slot   (sslot_v[j])
    );
  end

  // OR the one-hot select bus and rank codes across the row
  always_comb begin
    row_rank = '0;
    row_cost = '0;
    row_slot = '0;
    for (int k = 0; k < POP_DEPTH; k++) begin
      row_rank = row_rank | code_v[k];
      row_cost = row_cost | scost_v[k];
      row_slot = row_slot | sslot_v[k];
    end
    any_hit = |hit_vec;
    mv_slot = row_slot;
  end

  // Form the result beat
  always_comb begin
    status_next      = ST_OK;
    found_next       = 1'b0;
    final_rank_next  = '0;
    buffer_slot_next = '0;
    entry_cost_next  = '0;
    count_next       = count;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          final_rank_next  = row_rank;
          buffer_slot_next = row_slot;
          count_next       = count + CNT_W'(1);
        end
      end
      CMD_LOOKUP: begin
        if (any_hit) begin
          found_next       = 1'b1;
          final_rank_next  = row_rank;
          buffer_slot_next = row_slot;
        end
      end
      CMD_REPLACE: begin
        if (!rank_ok) begin
          status_next = ST_RANK;
        end else begin
          final_rank_next  = row_rank;
          buffer_slot_next = row_slot;
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      CMD_READ: begin
        if (!rank_ok) begin
          status_next = ST_RANK;
        end else begin
          entry_cost_next  = FCOST_W'(row_cost);
          buffer_slot_next = row_slot;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Advance the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_fire) begin
      count <= count_next;
    end
  end

  // Result register: load on execute, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status           <= status_next;
      found            <= found_next;
      final_rank       <= final_rank_next;
      buffer_slot      <= buffer_slot_next;
      entry_cost       <= entry_cost_next;
      population_count <= count_next;
    end
  end

  // An applied shift places the new cost in exactly one rank
  a_put_onehot : assert property (@(posedge clk) disable iff (rst)
    ctl.apply |-> $onehot(put_vec))
    else $error("shift did not place the cost in exactly one rank");

  // A lookup hits at most one rank
  a_hit_onehot0 : assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("lookup hit more than one rank");

  // A successful insert grows the population by one
  a_insert_count : assert property (@(posedge clk) disable iff (rst)
    exec_fire && is_insert && !full |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the population by one");

  // The population never exceeds the row
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> int'(count) <= POP_DEPTH)
    else $error("population exceeds the row depth");

  // A clear empties the table
  a_clear_empty : assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> count == '0)
    else $error("clear left entries in the table");

endmodule

`default_nettype wire
